/* design/mmp_pkg.sv */
// ----------------------------------------------------------------------------
// mmp_pkg
// shared sizes and sequencer states of the markov miss prefetcher
// ----------------------------------------------------------------------------
package mmp_pkg;

    localparam int ADDR_W  = 58;
    localparam int DATA_W  = 64;
    localparam int CNT_W   = 16;
    localparam int ROWS    = 256;
    localparam int ROW_W   = 8;
    localparam int WAYS    = 4;
    localparam int WAY_W   = 2;
    localparam int LIM_W   = 9;
    localparam int AGE_W   = 8;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_SCAN  = 13'b0000000000010,
        ST_CHK   = 13'b0000000000100,
        ST_PRED  = 13'b0000000001000,
        ST_LSEL  = 13'b0000000010000,
        ST_LRD   = 13'b0000000100000,
        ST_LWR   = 13'b0000001000000,
        ST_TOUCH = 13'b0000010000000,
        ST_EVICT = 13'b0000100000000,
        ST_EVD   = 13'b0001000000000,
        ST_ALLOC = 13'b0010000000000,
        ST_AWR   = 13'b0100000000000,
        ST_PUT   = 13'b1000000000000
    } t_state;

endpackage

/* design/markov_miss_prefetcher_unit.sv */
// ----------------------------------------------------------------------------
// markov_miss_prefetcher_unit
// markov miss prefetcher: row table in lru order, four counted successors
// per row, one proposal word per miss word
// ----------------------------------------------------------------------------
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata: block_addr
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tuser: prefetch_valid,
//                                                    tdata: prefetch_block
//  cfg       in   i_cfg_we                           i_cfg_wdata: rows_limit
//
//  first miss or zero row limit: straight to the output; otherwise a tag scan,
//  a prediction read of the ways when the missed block has a row, then a way
//  read, write and age scan, or a row alloc scan and way writes after an
//  evict scan per evicted row; all scans walk the memories one entry a cycle
//  through one compare unit
//  reset (synchronous, active low) clears valid bits, counters and the fsm;
//  no clearing pass, row contents are rewritten when a row is made
//  the result waits in an output register, so a new word can be taken while
//  it stalls; the next result waits until that register drains
// ----------------------------------------------------------------------------
module markov_miss_prefetcher_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [mmp_pkg::LIM_W-1:0] i_cfg_wdata,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [mmp_pkg::DATA_W-1:0] i_s_axis_tdata,   // [57:0] block_addr
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [mmp_pkg::DATA_W-1:0] o_m_axis_tdata,   // [57:0] prefetch_block
    output logic [0:0]                o_m_axis_tuser     // [0] prefetch_valid
);
    import mmp_pkg::*;

    localparam logic [LIM_W-1:0] LIM_ROWS = LIM_W'(ROWS);
    localparam logic [LIM_W-1:0] LIM_WAYS = LIM_W'(WAYS);
    localparam logic [CNT_W-1:0] CNT_TOP  = '1;

    // memories
    logic [ADDR_W-1:0] src_mem [ROWS];
    logic [AGE_W-1:0]  age_mem [ROWS];
    logic [ADDR_W-1:0] wa_mem  [ROWS*WAYS];
    logic [CNT_W-1:0]  wc_mem  [ROWS*WAYS];

    logic [ADDR_W-1:0] src_q, wa_q;
    logic [AGE_W-1:0]  age_q;
    logic [CNT_W-1:0]  wc_q;

    t_state r_state, n_state;
    logic [LIM_W-1:0] r_idx;
    logic             r_pv;
    logic [ROW_W-1:0] r_pidx;
    logic [ROWS-1:0]  r_valid;
    logic [LIM_W-1:0] r_held, r_limit;
    logic [ADDR_W-1:0] r_miss, r_last;
    logic             r_first;

    logic             r_hit_m, r_hit_l;
    logic [ROW_W-1:0] r_row_m, r_row_l;
    logic [AGE_W-1:0] r_old_age;

    logic             r_any;
    logic [CNT_W-1:0] r_best_c;
    logic [ADDR_W-1:0] r_best_a;

    logic             r_kn, r_em;
    logic [WAY_W-1:0] r_kn_w, r_em_w, r_min_w;
    logic [CNT_W-1:0] r_kn_c, r_min_c;
    logic [ADDR_W-1:0] r_min_a;

    logic             r_vic_f, r_free_f;
    logic [ROW_W-1:0] r_vic, r_free;
    logic [AGE_W-1:0] r_vic_age;

    logic             r_ov, r_ouser;
    logic [ADDR_W-1:0] r_odata;

    logic [LIM_W-1:0] lim;
    logic             row_scan, way_scan, issue, last_p, in_acc, out_free;
    logic [LIM_W-1:0] scan_cnt;
    logic [ROW_W-1:0] way_row;
    logic [ROW_W+WAY_W-1:0] w_rd_addr, w_wr_addr;
    logic             v_p;
    logic             age_we, w_we;
    logic [AGE_W-1:0] age_wd;
    logic [ROW_W-1:0] age_wa;
    logic [ADDR_W-1:0] wa_wd;
    logic [CNT_W-1:0] wc_wd;
    logic [LIM_W-1:0] held_dn;
    t_state           learn_next;

    assign lim      = (r_limit > LIM_ROWS) ? LIM_ROWS : r_limit;
    assign row_scan = (r_state == ST_SCAN) || (r_state == ST_TOUCH) ||
                      (r_state == ST_EVICT) || (r_state == ST_ALLOC);
    assign way_scan = (r_state == ST_PRED) || (r_state == ST_LRD);
    assign scan_cnt = way_scan ? LIM_WAYS : LIM_ROWS;
    assign issue    = (row_scan || way_scan) && (r_idx < scan_cnt);
    assign last_p   = r_pv && (LIM_W'(r_pidx) == scan_cnt - LIM_W'(1));
    assign v_p      = r_valid[r_pidx];
    assign way_row  = (r_state == ST_PRED) ? r_row_m : r_row_l;
    assign w_rd_addr = {way_row, r_idx[WAY_W-1:0]};
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ov || i_m_axis_tready;
    assign held_dn  = r_held - LIM_W'(1);
    assign learn_next = r_hit_l ? ST_LRD : ((r_held >= lim) ? ST_EVICT : ST_ALLOC);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tdata  = {{(DATA_W-ADDR_W){1'b0}}, r_odata};

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc) begin
                n_state = (lim == '0 || r_first) ? ST_PUT : ST_SCAN;
            end
            ST_SCAN:  if (last_p) n_state = ST_CHK;
            ST_CHK:   n_state = r_hit_m ? ST_PRED : ST_LSEL;
            ST_PRED:  if (last_p) n_state = ST_LSEL;
            ST_LSEL:  n_state = learn_next;
            ST_LRD:   if (last_p) n_state = ST_LWR;
            ST_LWR:   n_state = ST_TOUCH;
            ST_TOUCH: if (last_p) n_state = ST_PUT;
            ST_EVICT: if (last_p) n_state = ST_EVD;
            ST_EVD:   n_state = (held_dn >= lim) ? ST_EVICT : ST_ALLOC;
            ST_ALLOC: if (last_p) n_state = ST_AWR;
            ST_AWR:   if (r_idx[WAY_W-1:0] == WAY_W'(WAYS-1)) n_state = ST_PUT;
            ST_PUT:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // age and successor write ports
    always_comb begin
        age_we = 1'b0;
        age_wa = r_pidx;
        age_wd = age_q + AGE_W'(1);
        if (r_state == ST_TOUCH && r_pv && v_p) begin
            if (r_pidx == r_row_l) begin
                age_we = 1'b1;
                age_wd = '0;
            end else if (age_q < r_old_age) begin
                age_we = 1'b1;
            end
        end else if (r_state == ST_ALLOC && r_pv && v_p) begin
            age_we = 1'b1;
        end else if (r_state == ST_AWR && r_idx == '0) begin
            age_we = 1'b1;
            age_wa = r_free;
            age_wd = '0;
        end
    end

    always_comb begin
        w_we      = 1'b0;
        w_wr_addr = {r_free, r_idx[WAY_W-1:0]};
        wa_wd     = r_miss;
        wc_wd     = (r_idx == '0) ? CNT_W'(1) : '0;
        if (r_state == ST_AWR) begin
            w_we = 1'b1;
        end else if (r_state == ST_LWR) begin
            w_we = 1'b1;
            if (r_kn) begin
                w_wr_addr = {r_row_l, r_kn_w};
                wc_wd     = (r_kn_c != CNT_TOP) ? r_kn_c + CNT_W'(1) : r_kn_c;
            end else begin
                w_wr_addr = {r_row_l, r_em ? r_em_w : r_min_w};
                wc_wd     = CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        src_q <= src_mem[r_idx[ROW_W-1:0]];
        age_q <= age_mem[r_idx[ROW_W-1:0]];
        wa_q  <= wa_mem[w_rd_addr];
        wc_q  <= wc_mem[w_rd_addr];
        if (age_we) age_mem[age_wa] <= age_wd;
        if (r_state == ST_AWR && r_idx == '0) src_mem[r_free] <= r_last;
        if (w_we) begin
            wa_mem[w_wr_addr] <= wa_wd;
            wc_mem[w_wr_addr] <= wc_wd;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_pv    <= 1'b0;
            r_valid <= '0;
            r_held  <= '0;
            r_limit <= LIM_ROWS;
            r_last  <= '0;
            r_first <= 1'b1;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= issue;
            if (n_state != r_state) r_idx <= '0;
            else if (issue || r_state == ST_AWR) r_idx <= r_idx + LIM_W'(1);
            if (i_cfg_we) r_limit <= i_cfg_wdata;
            if (in_acc) r_first <= 1'b0;
            if (r_state == ST_EVD) begin
                r_valid[r_vic] <= 1'b0;
                r_held         <= held_dn;
            end
            if (r_state == ST_AWR && r_idx == '0) begin
                r_valid[r_free] <= 1'b1;
                r_held          <= r_held + LIM_W'(1);
            end
            if (r_state == ST_PUT && out_free) begin
                r_ov   <= 1'b1;
                r_last <= r_miss;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // scan datapath
    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx[ROW_W-1:0];
        if (in_acc) begin
            r_miss   <= i_s_axis_tdata[ADDR_W-1:0];
            r_hit_m  <= 1'b0;
            r_hit_l  <= 1'b0;
            r_any    <= 1'b0;
            r_kn     <= 1'b0;
            r_em     <= 1'b0;
            r_free_f <= 1'b0;
        end
        if (r_state == ST_LSEL || r_state == ST_EVD) r_vic_f <= 1'b0;
        if (r_pv) begin
            case (r_state)
                ST_SCAN: begin
                    if (v_p && src_q == r_miss && !r_hit_m) begin
                        r_hit_m <= 1'b1;
                        r_row_m <= r_pidx;
                    end
                    if (v_p && src_q == r_last && !r_hit_l) begin
                        r_hit_l   <= 1'b1;
                        r_row_l   <= r_pidx;
                        r_old_age <= age_q;
                    end
                end
                ST_PRED: begin
                    if (wc_q != '0 && (!r_any || wc_q > r_best_c ||
                                       (wc_q == r_best_c && wa_q > r_best_a))) begin
                        r_any    <= 1'b1;
                        r_best_c <= wc_q;
                        r_best_a <= wa_q;
                    end
                end
                ST_LRD: begin
                    if (wc_q != '0 && wa_q == r_miss && !r_kn) begin
                        r_kn   <= 1'b1;
                        r_kn_w <= r_pidx[WAY_W-1:0];
                        r_kn_c <= wc_q;
                    end
                    if (wc_q == '0 && !r_em) begin
                        r_em   <= 1'b1;
                        r_em_w <= r_pidx[WAY_W-1:0];
                    end
                    if (r_pidx == '0 || wc_q < r_min_c ||
                        (wc_q == r_min_c && wa_q < r_min_a)) begin
                        r_min_w <= r_pidx[WAY_W-1:0];
                        r_min_c <= wc_q;
                        r_min_a <= wa_q;
                    end
                end
                ST_EVICT: begin
                    if (v_p && (!r_vic_f || age_q > r_vic_age)) begin
                        r_vic_f   <= 1'b1;
                        r_vic     <= r_pidx;
                        r_vic_age <= age_q;
                    end
                end
                ST_ALLOC: begin
                    if (!v_p && !r_free_f) begin
                        r_free_f <= 1'b1;
                        r_free   <= r_pidx;
                    end
                end
                default: ;
            endcase
        end
        if (r_state == ST_PUT && out_free) begin
            r_ouser <= r_any && (r_best_a != r_miss);
            r_odata <= (r_any && (r_best_a != r_miss)) ? r_best_a : '0;
        end
    end

`ifndef ASSERT_OFF
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= LIM_ROWS)
        else $error("row count above table size");

    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_AWR && r_idx == '0) |-> (r_held < lim && r_free_f))
        else $error("row made without a free row");

    a_no_pred_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("block nonzero without proposal");
`endif

endmodule
